[src/fbd_pkg.sv]
// Shared types, codes and helpers for the monochrome framebuffer draw engine.
// No dependencies; imported by fbd_store, the top level, the checker and the testbench.
package fbd_pkg;

    localparam int CW  = 13;
    localparam int SQW = 22;

    typedef logic signed [CW-1:0] t_crd;

    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_PIXEL  = 3'd1;
    localparam logic [2:0] CMD_LINE   = 3'd2;
    localparam logic [2:0] CMD_RECT   = 3'd3;
    localparam logic [2:0] CMD_CIRCLE = 3'd4;
    localparam logic [2:0] CMD_READ   = 3'd5;

    localparam logic [1:0] POP_RESET  = 2'd0;
    localparam logic [1:0] POP_SET    = 2'd1;
    localparam logic [1:0] POP_INVERT = 2'd2;

    typedef enum logic [2:0] {
        WM_READ,
        WM_XOR,
        WM_SET,
        WM_CLR,
        WM_ZERO
    } t_wmode;

    typedef struct packed {
        logic       vld;
        t_wmode     mode;
        logic [7:0] mask;
    } t_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR,
        ST_PLAN,
        ST_SPAN,
        ST_LINE,
        ST_CSQ,
        ST_CIRC,
        ST_RD,
        ST_WAIT
    } t_state;

    function automatic t_crd f_max(input t_crd a, input t_crd b);
        f_max = (a > b) ? a : b;
    endfunction

    function automatic t_crd f_min(input t_crd a, input t_crd b);
        f_min = (a < b) ? a : b;
    endfunction

    function automatic logic [7:0] f_span_mask(input logic [2:0] lo, input logic [2:0] hi);
        logic [7:0] m;
        m = '0;
        for (int k = 0; k < 8; k++) begin
            m[7-k] = (3'(k) >= lo) && (3'(k) <= hi);
        end
        f_span_mask = m;
    endfunction

endpackage

[src/fbd_store.sv]
// Framebuffer byte memory with a two-stage read-modify-write path.
// Forwards the previous cycle's write to a back-to-back access. Uses fbd_pkg.
module fbd_store #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fbd_pkg::t_req i_req,
    input  logic [AW-1:0] i_addr,
    output logic [7:0]    o_rd_data
);
    import fbd_pkg::*;

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_q;
    t_req          r_s1;
    logic [AW-1:0] r_s1_addr;
    logic          r_fw_vld;
    logic [AW-1:0] r_fw_addr;
    logic [7:0]    r_fw_data;
    logic [7:0]    cur;
    logic [7:0]    wdat;
    logic          we;

    always_comb begin
        cur = (r_fw_vld && (r_fw_addr == r_s1_addr)) ? r_fw_data : r_q;
        we  = r_s1.vld && (r_s1.mode != WM_READ);
        unique case (r_s1.mode)
            WM_XOR:  wdat = cur ^ r_s1.mask;
            WM_SET:  wdat = cur | r_s1.mask;
            WM_CLR:  wdat = cur & ~r_s1.mask;
            WM_ZERO: wdat = '0;
            default: wdat = cur;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_q <= r_mem[i_addr];
        if (we) begin
            r_mem[r_s1_addr] <= wdat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1     <= '0;
            r_fw_vld <= 1'b0;
        end else begin
            r_s1     <= i_req;
            r_fw_vld <= we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= i_addr;
        r_fw_addr <= r_s1_addr;
        r_fw_data <= wdat;
    end

    assign o_rd_data = cur;

endmodule

[src/mono_framebuffer_draw_engine_unit.sv]
// Top level of the monochrome framebuffer draw engine: command decode, shape walkers.
// Depends on fbd_pkg and fbd_store.
//
//  channel | dir | handshake        | fields
//  command | in  | start && !busy   | req_type x_a y_a x_b y_b pixel_op fill byte_addr
//  result  | out | o_done, 1 cycle  | read_data done_kind
//
// At most one byte read-modify-write per cycle through the memory port; plan steps issue
// none. After acceptance the walker states run, then the wait state registers the strobe:
// clear zeroes every byte, read reads one, line walks x, circle squares its terms then
// visits each pixel of its clipped bounding box, and pixel, vertical line or rectangle
// plan each row span, clipped or not, and write each covered byte. After reset a clearing
// pass over all bytes holds busy high. The result strobe cannot be stalled.
module mono_framebuffer_draw_engine_unit #(
    parameter int ROW_BYTES = 64,
    parameter int ROW_COUNT = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_req_type,
    input  logic signed [10:0] i_x_a,
    input  logic signed [10:0] i_y_a,
    input  logic signed [10:0] i_x_b,
    input  logic signed [10:0] i_y_b,
    input  logic [1:0]         i_pixel_op,
    input  logic               i_fill,
    input  logic [13:0]        i_byte_addr,
    output logic               o_done,
    output logic [7:0]         o_read_data,
    output logic [2:0]         o_done_kind
);
    import fbd_pkg::*;

    localparam int FBW   = ROW_BYTES * 8;
    localparam int DEPTH = ROW_BYTES * ROW_COUNT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic [AW-1:0] f_base(input t_crd y);
        f_base = AW'(32'($unsigned(y[CW-2:0])) * ROW_BYTES);
    endfunction

    t_state r_state, n_state;
    logic   acc;

    // command registers
    logic [2:0]    r_kind;
    logic          r_fill;
    t_wmode        r_mode;
    t_crd          r_xa, r_ya, r_x1, r_x2, r_y2;
    t_crd          r_y, r_hi;
    logic [1:0]    r_phase;
    logic          r_sub;
    logic          r_boot;
    logic [AW-1:0] r_ccnt;
    logic [13:0]   r_baddr;
    logic          r_rd_ok;
    logic          r_done;
    logic [7:0]    r_rdata;

    // span walker
    logic [AW-1:0] r_sp_base;
    logic [CW-4:0] r_sp_b, r_sp_bs, r_sp_be;
    logic [2:0]    r_sp_lo, r_sp_hi;

    // line walker
    t_crd          r_lx, r_lxe, r_ly0;
    logic [11:0]   r_dx, r_ady, r_q;
    logic [12:0]   r_rem;
    logic          r_neg;

    // circle walker
    t_crd          r_r, r_cx, r_cxlo, r_cxhi;
    logic [1:0]    r_csq;
    logic [SQW-1:0] r_r2, r_q2, r_dx0sq, r_dy2, r_d;
    logic [7:0]    r_acc;

    // accept-time decode
    t_crd sxa, sya, sxb, syb;
    t_crd rc_lo, rc_hi, vl_lo, vl_hi;
    t_crd c_ylo, c_yhi, c_xlo, c_xhi;
    t_crd l_xa, l_ya, l_xb, l_yb, l_dx, l_dy;
    logic c_ok, op_ok;
    t_wmode op_mode;

    // plan step
    t_crd pl_y, pl_a, pl_b, pl_xlo, pl_xhi;
    logic pl_last, pl_go;
    logic [1:0] pl_nphase;
    logic pl_nsub;
    t_crd pl_ny;

    // line and circle step
    logic ln_adj, ln_on;
    t_crd ln_y;
    t_crd sq_op;
    logic signed [2*CW-1:0] sq_full;
    logic [SQW-1:0] sq, n_dy2;
    logic [SQW:0]   n_d;
    t_crd cdx, cdy;
    logic c_in, c_emit, c_rowend;
    logic [7:0] c_bit, c_mask;

    t_req          q_req;
    logic [AW-1:0] q_addr;
    logic [7:0]    rd_data;

    assign acc = start && !busy;

    always_comb begin
        sxa = t_crd'(i_x_a);
        sya = t_crd'(i_y_a);
        sxb = t_crd'(i_x_b);
        syb = t_crd'(i_y_b);
        rc_lo = f_max(sya + t_crd'(1), t_crd'(0));
        rc_hi = f_min(sya + syb, t_crd'(ROW_COUNT - 1));
        vl_lo = f_max(f_min(sya, syb), t_crd'(0));
        vl_hi = f_min(f_max(sya, syb), t_crd'(ROW_COUNT - 1));
        c_ylo = f_max(sya - sxb + t_crd'(1), t_crd'(0));
        c_yhi = f_min(sya + sxb - t_crd'(1), t_crd'(ROW_COUNT - 1));
        c_xlo = f_max(sxa - sxb + t_crd'(1), t_crd'(0));
        c_xhi = f_min(sxa + sxb - t_crd'(1), t_crd'(FBW - 1));
        c_ok  = (sxb > t_crd'(0)) && (c_ylo <= c_yhi) && (c_xlo <= c_xhi);
        if (sxa > t_crd'(i_x_b)) begin
            l_xa = sxb; l_ya = syb; l_xb = sxa; l_yb = sya;
        end else begin
            l_xa = sxa; l_ya = sya; l_xb = sxb; l_yb = syb;
        end
        l_dx = l_xb - l_xa;
        l_dy = l_yb - l_ya;
        op_ok = 1'b1;
        unique case (i_pixel_op)
            POP_RESET:  op_mode = WM_CLR;
            POP_SET:    op_mode = WM_SET;
            POP_INVERT: op_mode = WM_XOR;
            default: begin
                op_mode = WM_XOR;
                op_ok   = 1'b0;
            end
        endcase
    end

    // pick the next row span of the current shape
    always_comb begin
        pl_y = '0; pl_a = '0; pl_b = '0;
        pl_last = 1'b0;
        pl_nphase = r_phase;
        pl_nsub = r_sub;
        pl_ny = r_y;
        priority if (r_kind == CMD_PIXEL) begin
            pl_y = r_ya; pl_a = r_xa; pl_b = r_xa;
            pl_nphase = 2'd1;
            pl_last = (r_phase != 2'd0);
        end else if (r_kind == CMD_LINE) begin
            pl_y = r_y; pl_a = r_xa; pl_b = r_xa;
            pl_ny = r_y + t_crd'(1);
            pl_last = (r_y > r_hi);
        end else if (r_kind == CMD_RECT && r_fill) begin
            pl_y = r_y; pl_a = r_x1; pl_b = r_x2;
            pl_ny = r_y + t_crd'(1);
            pl_last = (r_y > r_hi);
        end else if (r_kind == CMD_RECT) begin
            pl_a = r_x1; pl_b = r_x2;
            unique case (r_phase)
                2'd0: begin
                    pl_y = r_ya; pl_nphase = 2'd1;
                end
                2'd1: begin
                    pl_y = r_y2; pl_nphase = 2'd2;
                end
                default: begin
                    pl_y = r_y;
                    pl_last = (r_y > r_hi);
                    pl_nsub = !r_sub;
                    if (r_sub) begin
                        pl_a = r_x2; pl_b = r_x2;
                        pl_ny = r_y + t_crd'(1);
                    end else begin
                        pl_a = r_xa; pl_b = r_xa;
                    end
                end
            endcase
        end else begin
            pl_last = 1'b1;
        end
        pl_xlo = f_max(pl_a, t_crd'(0));
        pl_xhi = f_min(pl_b, t_crd'(FBW - 1));
        pl_go = !pl_last && (pl_y >= t_crd'(0)) && (pl_y < t_crd'(ROW_COUNT))
                && (pl_xlo <= pl_xhi);
    end

    always_comb begin
        ln_adj = (r_rem >= {1'b0, r_dx});
        ln_y = r_neg ? (r_ly0 - t_crd'({1'b0, r_q})) : (r_ly0 + t_crd'({1'b0, r_q}));
        ln_on = (r_lx >= t_crd'(0)) && (r_lx < t_crd'(FBW))
                && (ln_y >= t_crd'(0)) && (ln_y < t_crd'(ROW_COUNT));
    end

    always_comb begin
        unique case (r_csq)
            2'd0:    sq_op = r_r;
            2'd1:    sq_op = r_r - t_crd'(1);
            2'd2:    sq_op = r_cxlo - r_xa;
            default: sq_op = r_y - r_ya;
        endcase
        sq_full = sq_op * sq_op;
        sq = sq_full[SQW-1:0];
        cdx = r_cx - r_xa;
        cdy = r_y - r_ya;
        n_d = $signed({1'b0, r_d}) + (SQW+1)'(2 * cdx + 1);
        n_dy2 = SQW'($signed({1'b0, r_dy2}) + (SQW+1)'(2 * cdy + 1));
        c_in = (r_d < r_r2) && (r_fill || (r_d > r_q2));
        c_bit = 8'h80 >> r_cx[2:0];
        c_mask = r_acc | (c_in ? c_bit : 8'h00);
        c_rowend = (r_cx == r_cxhi);
        c_emit = (r_cx[2:0] == 3'd7) || c_rowend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        q_req = '0;
        q_addr = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    priority if (i_req_type == CMD_CLEAR) begin
                        n_state = ST_CLR;
                    end else if (i_req_type == CMD_PIXEL) begin
                        n_state = op_ok ? ST_PLAN : ST_WAIT;
                    end else if (i_req_type == CMD_LINE) begin
                        n_state = (sxa == sxb) ? ST_PLAN : ST_LINE;
                    end else if (i_req_type == CMD_RECT) begin
                        n_state = ST_PLAN;
                    end else if (i_req_type == CMD_CIRCLE) begin
                        n_state = c_ok ? ST_CSQ : ST_WAIT;
                    end else if (i_req_type == CMD_READ) begin
                        n_state = ST_RD;
                    end else begin
                        n_state = ST_WAIT;
                    end
                end
            end
            ST_CLR: begin
                q_req = '{vld: 1'b1, mode: WM_ZERO, mask: 8'h00};
                q_addr = r_ccnt;
                if (r_ccnt == AW'(DEPTH - 1)) begin
                    n_state = r_boot ? ST_IDLE : ST_WAIT;
                end
            end
            ST_PLAN: begin
                if (pl_last) begin
                    n_state = ST_WAIT;
                end else if (pl_go) begin
                    n_state = ST_SPAN;
                end
            end
            ST_SPAN: begin
                q_req.vld = 1'b1;
                q_req.mode = r_mode;
                q_req.mask = f_span_mask((r_sp_b == r_sp_bs) ? r_sp_lo : 3'd0,
                                         (r_sp_b == r_sp_be) ? r_sp_hi : 3'd7);
                q_addr = r_sp_base + AW'(r_sp_b);
                if (r_sp_b == r_sp_be) begin
                    n_state = ST_PLAN;
                end
            end
            ST_LINE: begin
                if (!ln_adj) begin
                    q_req.vld = ln_on;
                    q_req.mode = WM_XOR;
                    q_req.mask = 8'h80 >> r_lx[2:0];
                    q_addr = f_base(ln_y) + AW'(r_lx[CW-1:3]);
                    if (r_lx == r_lxe) begin
                        n_state = ST_WAIT;
                    end
                end
            end
            ST_CSQ: begin
                if (r_csq == 2'd3) begin
                    n_state = ST_CIRC;
                end
            end
            ST_CIRC: begin
                q_req.vld = c_emit;
                q_req.mode = WM_XOR;
                q_req.mask = c_mask;
                q_addr = r_sp_base + AW'(r_cx[CW-1:3]);
                if (c_rowend && (r_y == r_hi)) begin
                    n_state = ST_WAIT;
                end
            end
            ST_RD: begin
                q_req = '{vld: r_rd_ok, mode: WM_READ, mask: 8'h00};
                q_addr = AW'(r_baddr);
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ccnt <= '0;
            r_boot <= 1'b1;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == ST_WAIT);
            if (r_state == ST_CLR) begin
                r_ccnt <= r_ccnt + AW'(1);
            end else if (acc) begin
                r_ccnt <= '0;
                r_boot <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    r_kind <= i_req_type;
                    r_fill <= i_fill;
                    r_mode <= (i_req_type == CMD_PIXEL) ? op_mode : WM_XOR;
                    r_xa <= sxa;
                    r_ya <= sya;
                    r_x1 <= sxa + t_crd'(1);
                    r_x2 <= sxa + sxb;
                    r_y2 <= sya + syb;
                    r_phase <= 2'd0;
                    r_sub <= 1'b0;
                    r_baddr <= i_byte_addr;
                    r_rd_ok <= (32'(i_byte_addr) < DEPTH);
                    r_r <= sxb;
                    r_csq <= 2'd0;
                    r_cxlo <= c_xlo;
                    r_cxhi <= c_xhi;
                    r_cx <= c_xlo;
                    r_acc <= '0;
                    r_sp_base <= f_base(c_ylo);
                    r_lx <= l_xa;
                    r_lxe <= l_xb;
                    r_ly0 <= l_ya;
                    r_dx <= l_dx[11:0];
                    r_neg <= l_dy[CW-1];
                    r_ady <= l_dy[CW-1] ? 12'(-l_dy) : l_dy[11:0];
                    r_q <= '0;
                    r_rem <= '0;
                    priority if (i_req_type == CMD_RECT) begin
                        r_y <= rc_lo;
                        r_hi <= rc_hi;
                    end else if (i_req_type == CMD_CIRCLE) begin
                        r_y <= c_ylo;
                        r_hi <= c_yhi;
                    end else begin
                        r_y <= vl_lo;
                        r_hi <= vl_hi;
                    end
                end
            end
            ST_PLAN: begin
                r_phase <= pl_nphase;
                r_sub <= pl_nsub;
                r_y <= pl_ny;
                r_sp_base <= f_base(pl_y);
                r_sp_b <= pl_xlo[CW-1:3];
                r_sp_bs <= pl_xlo[CW-1:3];
                r_sp_be <= pl_xhi[CW-1:3];
                r_sp_lo <= pl_xlo[2:0];
                r_sp_hi <= pl_xhi[2:0];
            end
            ST_SPAN: begin
                r_sp_b <= r_sp_b + 1'b1;
            end
            ST_LINE: begin
                if (ln_adj) begin
                    r_rem <= r_rem - {1'b0, r_dx};
                    r_q <= r_q + 12'd1;
                end else begin
                    r_lx <= r_lx + t_crd'(1);
                    r_rem <= r_rem + {1'b0, r_ady};
                end
            end
            ST_CSQ: begin
                r_csq <= r_csq + 2'd1;
                unique case (r_csq)
                    2'd0: r_r2 <= sq;
                    2'd1: r_q2 <= sq;
                    2'd2: r_dx0sq <= sq;
                    default: begin
                        r_dy2 <= sq;
                        r_d <= r_dx0sq + sq;
                    end
                endcase
            end
            ST_CIRC: begin
                if (c_rowend) begin
                    r_y <= r_y + t_crd'(1);
                    r_dy2 <= n_dy2;
                    r_d <= r_dx0sq + n_dy2;
                    r_sp_base <= r_sp_base + AW'(ROW_BYTES);
                    r_cx <= r_cxlo;
                    r_acc <= '0;
                end else begin
                    r_cx <= r_cx + t_crd'(1);
                    r_d <= n_d[SQW-1:0];
                    r_acc <= c_emit ? 8'h00 : c_mask;
                end
            end
            ST_WAIT: begin
                r_rdata <= ((r_kind == CMD_READ) && r_rd_ok) ? rd_data : 8'h00;
            end
            default: begin
            end
        endcase
    end

    fbd_store #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (q_req),
        .i_addr   (q_addr),
        .o_rd_data(rd_data)
    );

    assign busy        = (r_state != ST_IDLE);
    assign o_done      = r_done;
    assign o_read_data = r_rdata;
    assign o_done_kind = r_kind;

    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> busy)
        else $error("command transaction did not raise busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) && !busy))
        else $error("result strobe outside command completion");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !q_req.vld)
        else $error("memory access while idle");

endmodule

[dv/mono_framebuffer_draw_engine_unit_checker.sv]
// Checker for the monochrome framebuffer draw engine: keeps a pixel-exact framebuffer copy,
// predicts the result of each command transaction and compares it with the result strobe.
// Depends on fbd_pkg.
module mono_framebuffer_draw_engine_unit_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         i_req_type,
    input  logic signed [10:0] i_x_a,
    input  logic signed [10:0] i_y_a,
    input  logic signed [10:0] i_x_b,
    input  logic signed [10:0] i_y_b,
    input  logic [1:0]         i_pixel_op,
    input  logic               i_fill,
    input  logic [13:0]        i_byte_addr,
    input  logic               o_done,
    input  logic [7:0]         o_read_data,
    input  logic [2:0]         o_done_kind,
    output int                 errors,
    output int                 pending
);
    import fbd_pkg::*;

    localparam int ROW_BYTES = 64;
    localparam int ROW_COUNT = 256;
    localparam int FB_BYTES  = ROW_BYTES * ROW_COUNT;
    localparam int FB_WIDTH  = ROW_BYTES * 8;

    typedef struct {
        logic [7:0] data;
        logic [2:0] kind;
    } t_done;

    logic [7:0] frame [FB_BYTES];
    t_done      done_q [$];

    initial errors = 0;
    initial pending = 0;

    function automatic void plot(input int x, input int y, input logic [1:0] mode);
        int         idx;
        logic [7:0] mask;
        if (x < 0 || x >= FB_WIDTH || y < 0 || y >= ROW_COUNT) return;
        idx  = y * ROW_BYTES + x / 8;
        mask = 8'h80 >> (x % 8);
        case (mode)
            POP_RESET:  frame[idx] = frame[idx] & ~mask;
            POP_SET:    frame[idx] = frame[idx] | mask;
            POP_INVERT: frame[idx] = frame[idx] ^ mask;
            default: ;
        endcase
    endfunction

    function automatic void trace_line(input int x1, input int y1, input int x2, input int y2);
        int xa, ya, xb, yb, lo, hi;
        if (x1 == x2) begin
            lo = (y1 < y2) ? y1 : y2;
            hi = (y1 < y2) ? y2 : y1;
            for (int y = lo; y <= hi; y++) plot(x1, y, POP_INVERT);
            return;
        end
        if (x1 > x2) begin
            xa = x2; ya = y2; xb = x1; yb = y1;
        end else begin
            xa = x1; ya = y1; xb = x2; yb = y2;
        end
        for (int i = 0; i <= xb - xa; i++)
            plot(xa + i, ya + ((yb - ya) * i) / (xb - xa), POP_INVERT);
    endfunction

    function automatic void toggle_row(input int y, input int xlo, input int xhi);
        if (y < 0 || y >= ROW_COUNT) return;
        if (xlo < 0) xlo = 0;
        if (xhi > FB_WIDTH - 1) xhi = FB_WIDTH - 1;
        for (int x = xlo; x <= xhi; x++) plot(x, y, POP_INVERT);
    endfunction

    function automatic void trace_rect(input int ox, input int oy, input int rx, input int ry,
                                       input logic full);
        int lo, hi;
        lo = (oy + 1 > 0) ? oy + 1 : 0;
        hi = (oy + ry < ROW_COUNT - 1) ? oy + ry : ROW_COUNT - 1;
        if (full) begin
            for (int y = lo; y <= hi; y++) toggle_row(y, ox + 1, ox + rx);
            return;
        end
        toggle_row(oy, ox + 1, ox + rx);
        toggle_row(oy + ry, ox + 1, ox + rx);
        for (int y = lo; y <= hi; y++) begin
            plot(ox, y, POP_INVERT);
            plot(ox + rx, y, POP_INVERT);
        end
    endfunction

    function automatic void trace_circle(input int ox, input int oy, input int r,
                                         input logic full);
        int ylo, yhi, xlo, xhi, d;
        if (r <= 0) return;
        ylo = (oy - r + 1 > 0) ? oy - r + 1 : 0;
        yhi = (oy + r - 1 < ROW_COUNT - 1) ? oy + r - 1 : ROW_COUNT - 1;
        xlo = (ox - r + 1 > 0) ? ox - r + 1 : 0;
        xhi = (ox + r - 1 < FB_WIDTH - 1) ? ox + r - 1 : FB_WIDTH - 1;
        for (int y = ylo; y <= yhi; y++)
            for (int x = xlo; x <= xhi; x++) begin
                d = (x - ox) * (x - ox) + (y - oy) * (y - oy);
                if (d < r * r && (full || d > (r - 1) * (r - 1))) plot(x, y, POP_INVERT);
            end
    endfunction

    function automatic t_done run_command();
        t_done res;
        res.data = '0;
        res.kind = i_req_type;
        case (i_req_type)
            CMD_CLEAR:  foreach (frame[k]) frame[k] = '0;
            CMD_PIXEL:  plot(int'(i_x_a), int'(i_y_a), i_pixel_op);
            CMD_LINE:   trace_line(int'(i_x_a), int'(i_y_a), int'(i_x_b), int'(i_y_b));
            CMD_RECT:   trace_rect(int'(i_x_a), int'(i_y_a), int'(i_x_b), int'(i_y_b), i_fill);
            CMD_CIRCLE: trace_circle(int'(i_x_a), int'(i_y_a), int'(i_x_b), i_fill);
            CMD_READ:   if (int'(i_byte_addr) < FB_BYTES) res.data = frame[i_byte_addr];
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_done want;
        if (!i_rst_n) begin
            foreach (frame[k]) frame[k] = '0;
            done_q.delete();
        end else begin
            if (o_done) begin
                if (done_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: read_data=%h done_kind=%0d",
                                 o_read_data, o_done_kind);
                end else begin
                    want = done_q.pop_front();
                    if (want.data !== o_read_data || want.kind !== o_done_kind) begin
                        errors++;
                        if (errors <= 10)
                            $display("result mismatch: expected data=%h kind=%0d, got data=%h kind=%0d",
                                     want.data, want.kind, o_read_data, o_done_kind);
                    end
                end
            end
            if (start && !busy) done_q.push_back(run_command());
        end
        pending <= done_q.size();
    end

endmodule

[dv/mono_framebuffer_draw_engine_unit_tb.sv]
// Testbench top for the monochrome framebuffer draw engine: clock, reset, command stimulus,
// watchdog and verdict. Depends on fbd_pkg, the engine and its checker.
module mono_framebuffer_draw_engine_unit_tb;
    import fbd_pkg::*;

    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;
    localparam logic [1:0] POP_NONE    = 2'd3;
    localparam int         STALL_LIMIT = 600000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         i_req_type = '0;
    logic signed [10:0] i_x_a = '0;
    logic signed [10:0] i_y_a = '0;
    logic signed [10:0] i_x_b = '0;
    logic signed [10:0] i_y_b = '0;
    logic [1:0]         i_pixel_op = '0;
    logic               i_fill = 1'b0;
    logic [13:0]        i_byte_addr = '0;
    logic               o_done;
    logic [7:0]         o_read_data;
    logic [2:0]         o_done_kind;
    int                 errors;
    int                 pending;
    int                 quiet_cycles = 0;
    int                 idle_pct = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    mono_framebuffer_draw_engine_unit DUT (.*);

    mono_framebuffer_draw_engine_unit_checker checker_i (.*);

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("mono_framebuffer_draw_engine_unit test failed");
            $finish;
        end
    end

    task automatic send_cmd(input logic [2:0] kind, input int xa, input int ya, input int xb,
                            input int yb, input logic [1:0] op, input logic fl,
                            input logic [13:0] addr);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_req_type  <= kind;
        i_x_a       <= 11'(xa);
        i_y_a       <= 11'(ya);
        i_x_b       <= 11'(xb);
        i_y_b       <= 11'(yb);
        i_pixel_op  <= op;
        i_fill      <= fl;
        i_byte_addr <= addr;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic int pick_coord(input int hi);
        if ($urandom_range(9) == 0) return int'($signed(11'($urandom_range(2047))));
        return $urandom_range(hi);
    endfunction

    initial begin
        logic [2:0]  kind;
        logic [13:0] addr;
        int          r;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 35;
        send_cmd(CMD_PIXEL, 0, 0, 0, 0, POP_SET, 1'b0, '0);
        send_cmd(CMD_PIXEL, 511, 255, 0, 0, POP_SET, 1'b0, '0);
        send_cmd(CMD_PIXEL, -1, 5, 0, 0, POP_SET, 1'b0, '0);
        send_cmd(CMD_PIXEL, 512, 0, 0, 0, POP_INVERT, 1'b0, '0);
        send_cmd(CMD_PIXEL, 3, 0, 0, 0, POP_INVERT, 1'b0, '0);
        send_cmd(CMD_PIXEL, 0, 0, 0, 0, POP_NONE, 1'b0, '0);
        send_cmd(CMD_READ, 0, 0, 0, 0, POP_RESET, 1'b0, 14'd0);
        send_cmd(CMD_PIXEL, 0, 0, 0, 0, POP_RESET, 1'b0, '0);
        send_cmd(CMD_READ, 0, 0, 0, 0, POP_RESET, 1'b0, 14'd16383);
        send_cmd(CMD_LINE, 5, 10, 5, 3, POP_RESET, 1'b0, '0);
        send_cmd(CMD_LINE, 40, 2, 8, 6, POP_RESET, 1'b0, '0);
        send_cmd(CMD_LINE, 0, 0, 3, 200, POP_RESET, 1'b0, '0);
        send_cmd(CMD_LINE, -1024, -1024, 1023, 1023, POP_RESET, 1'b0, '0);
        send_cmd(CMD_RECT, 10, 10, 20, 5, POP_RESET, 1'b1, '0);
        send_cmd(CMD_RECT, 30, 30, -5, 4, POP_RESET, 1'b0, '0);
        send_cmd(CMD_RECT, 100, 50, 0, 0, POP_RESET, 1'b0, '0);
        send_cmd(CMD_CIRCLE, 60, 20, 0, 0, POP_RESET, 1'b1, '0);
        send_cmd(CMD_CIRCLE, 60, 20, -3, 0, POP_RESET, 1'b0, '0);
        send_cmd(CMD_CIRCLE, 60, 20, 10, 0, POP_RESET, 1'b0, '0);
        send_cmd(CMD_CIRCLE, 0, 0, 5, 0, POP_RESET, 1'b1, '0);
        send_cmd(CMD_CIRCLE, 256, 128, 1023, 0, POP_RESET, 1'b1, '0);
        send_cmd(CMD_SPARE_A, 1, 1, 1, 1, POP_SET, 1'b1, 14'd3);
        send_cmd(CMD_SPARE_B, 1, 1, 1, 1, POP_SET, 1'b1, 14'd3);
        send_cmd(CMD_READ, 0, 0, 0, 0, POP_RESET, 1'b0, 14'd641);
        send_cmd(CMD_CLEAR, 0, 0, 0, 0, POP_RESET, 1'b0, '0);
        drain();

        for (int n = 0; n < 100; n++) begin
            idle_pct = (n < 33) ? 35 : (n < 66) ? 52 : 0;
            if ($urandom_range(9) < 3) kind = CMD_READ;
            else kind = 3'($urandom_range(0, 7));
            if (kind == CMD_CLEAR && $urandom_range(3) != 0) kind = CMD_PIXEL;
            addr = ($urandom_range(4) == 0) ? 14'($urandom) :
                   14'($urandom_range(31) * 64 + $urandom_range(15));
            r = ($urandom_range(29) == 0) ? int'($signed(11'($urandom))) : $urandom_range(14);
            if (kind == CMD_CIRCLE)
                send_cmd(kind, pick_coord(120), pick_coord(40), r, pick_coord(40),
                         2'($urandom), 1'($urandom), addr);
            else
                send_cmd(kind, pick_coord(120), pick_coord(40), pick_coord(120),
                         pick_coord(40), 2'($urandom), 1'($urandom), addr);
        end
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("mono_framebuffer_draw_engine_unit test passed");
        else
            $display("mono_framebuffer_draw_engine_unit test failed");
        $finish;
    end

endmodule
